[hw/rtl/tsd_pkg.sv]
// Shared types and constants of the token scanner DFA.
package tsd_pkg;

  typedef enum logic [4:0] {
    K_PLUS, K_MINUS, K_MUL, K_DIV, K_LT, K_LE, K_GT, K_GE, K_EQ, K_NE,
    K_DEF, K_ENDDEF, K_DRVDEF, K_DRVENDDEF, K_COLON, K_RANGE, K_SEMI,
    K_COMMA, K_ASSIGN, K_SQBO, K_SQBC, K_BO, K_BC, K_NUM, K_RNUM, K_ID,
    K_ERR, K_END
  } kind_e;

  typedef enum logic [4:0] {
    S_START, S_INT, S_INTDOT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPDIG, S_ID,
    S_STAR, S_CMT, S_CMTSTAR, S_LT, S_LTLT, S_GT, S_GTGT, S_BANG, S_EQ,
    S_COLON, S_DOT
  } scan_state_e;

  localparam int unsigned LINE_W = 24;
  localparam int unsigned START_W = 32;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned VAL_W = 31;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    kind_e               kind;
    logic [LINE_W-1:0]   line;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [VAL_W-1:0]    val;
    logic                last;
  } tok_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LZ     = 8'h7A;

endpackage

[hw/rtl/token_scanner_dfa_unit.sv]
// Top level of the token scanner DFA: input register, scan step and result queue.
//
// Usage: source bytes enter on the input channel (in_valid_i, in_stall_o,
// in_byte_i), one byte per item; byte 0 marks the end of the input. Tokens
// leave on the output channel (out_valid_o, out_stall_i and the token_* and
// int_value_o fields). A byte gives zero, one or two tokens; last_of_run_o
// marks the final token caused by a byte.
// Path: a byte is taken into the input register and scanned from there; the
// tokens that it gives are written into the result queue, whose head drives
// the output channel.
// Throughput: one byte per cycle while the queue has room. The output side
// moves one token per cycle unless out_stall_i is high, so a byte that gives
// two tokens leaves more slowly than it is scanned; the four-entry result queue
// absorbs that, and the scan step waits only when fewer than two entries are free.
// Reset: the scanner returns to the start state, the byte offset to 0, the
// line count to 1, and the queue is emptied.
// When the receiver stalls, the queue fills and then in_stall_o rises while
// a byte waits in the input register; no item is lost or repeated.
module token_scanner_dfa_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [23:0] token_line_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [30:0] int_value_o,
  output logic        last_of_run_o
);
  import tsd_pkg::*;

  localparam int unsigned SW = (OFFSET_BITS < START_W) ? OFFSET_BITS : START_W;
  localparam int unsigned QD = 4;
  localparam int unsigned QPW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);
  localparam int unsigned LCW = LEN_W + 1;

  // Input register
  logic       s1_vld_q, s1_vld_d;
  logic [7:0] s1_byte_q;
  logic       in_acc, step, room;

  // Scanner state
  scan_state_e           st_q, st_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, lst_q, lst_d, pos_m1;
  logic [LINE_W-1:0]     line_q, line_d;
  logic [VAL_W-1:0]      acc_q, acc_d, acc_next;
  logic [LCW-1:0]        len_q, len_d, len_inc;
  logic [VAL_W+3:0]      acc_wide;

  // Result queue
  tok_t             fifo_q [QD];
  logic [QPW-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             pop;

  logic [7:0]         c;
  logic [START_W-1:0] pos32, lst32, pm1_32;

  // Start-state decode of the current byte
  logic        sb_emit, sb_len0, sb_nl, sb_dig;
  kind_e       sb_kind;
  scan_state_e sb_state;

  // Tokens of this step
  logic  p_vld, x_vld, do_sb, sb_vld;
  tok_t  p_tok, x_tok, sb_tok, r0, r1;
  logic [1:0] n_res;

  logic is_dig, is_alpha;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LCW-1:0] v);
    return v[LCW-1] ? '1 : v[LEN_W-1:0];
  endfunction

  assign c        = s1_byte_q;
  assign is_dig   = c inside {[CH_ZERO:CH_NINE]};
  assign is_alpha = c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};

  assign room       = (cnt_q <= QCW'(QD - 2));
  assign step       = s1_vld_q && room;
  assign in_stall_o = s1_vld_q && !room;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  assign pos_m1 = pos_q - OFFSET_BITS'(1);
  assign pos32  = START_W'(pos_q[SW-1:0]);
  assign lst32  = START_W'(lst_q[SW-1:0]);
  assign pm1_32 = START_W'(pos_m1[SW-1:0]);

  assign len_inc  = (len_q == '1) ? len_q : len_q + LCW'(1);
  assign acc_wide = (VAL_W+4)'({acc_q, 3'b000}) + (VAL_W+4)'({acc_q, 1'b0})
                  + (VAL_W+4)'(c[3:0]);
  assign acc_next = (acc_wide > (VAL_W+4)'(VAL_MAX)) ? VAL_MAX : acc_wide[VAL_W-1:0];

  always_comb begin
    sb_emit  = 1'b0;
    sb_len0  = 1'b0;
    sb_nl    = 1'b0;
    sb_dig   = 1'b0;
    sb_kind  = K_ERR;
    sb_state = S_START;
    case (c)
      CH_PLUS:  begin sb_emit = 1'b1; sb_kind = K_PLUS;  end
      CH_MINUS: begin sb_emit = 1'b1; sb_kind = K_MINUS; end
      CH_SLASH: begin sb_emit = 1'b1; sb_kind = K_DIV;   end
      CH_LSQ:   begin sb_emit = 1'b1; sb_kind = K_SQBO;  end
      CH_RSQ:   begin sb_emit = 1'b1; sb_kind = K_SQBC;  end
      CH_LPAR:  begin sb_emit = 1'b1; sb_kind = K_BO;    end
      CH_RPAR:  begin sb_emit = 1'b1; sb_kind = K_BC;    end
      CH_COMMA: begin sb_emit = 1'b1; sb_kind = K_COMMA; end
      CH_SEMI:  begin sb_emit = 1'b1; sb_kind = K_SEMI;  end
      CH_BANG:  sb_state = S_BANG;
      CH_EQ:    sb_state = S_EQ;
      CH_COLON: sb_state = S_COLON;
      CH_DOT:   sb_state = S_DOT;
      CH_LT:    sb_state = S_LT;
      CH_GT:    sb_state = S_GT;
      CH_STAR:  sb_state = S_STAR;
      CH_NL:    sb_nl = 1'b1;
      CH_TAB, CH_SPACE: ;
      CH_NUL: begin
        sb_emit = 1'b1;
        sb_kind = K_END;
        sb_len0 = 1'b1;
      end
      default: begin
        if (is_alpha) begin
          sb_state = S_ID;
        end else if (is_dig) begin
          sb_state = S_INT;
          sb_dig   = 1'b1;
        end else begin
          sb_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    st_d   = st_q;
    lst_d  = lst_q;
    len_d  = len_q;
    acc_d  = acc_q;
    line_d = line_q;
    pos_d  = pos_q + OFFSET_BITS'(1);
    p_vld  = 1'b0;
    x_vld  = 1'b0;
    do_sb  = 1'b0;

    p_tok.kind  = K_ERR;
    p_tok.line  = line_q;
    p_tok.start = lst32;
    p_tok.len   = sat_len(len_q);
    p_tok.val   = '0;
    p_tok.last  = 1'b0;

    x_tok.kind  = K_RANGE;
    x_tok.line  = line_q;
    x_tok.start = pm1_32;
    x_tok.len   = LEN_W'(2);
    x_tok.val   = '0;
    x_tok.last  = 1'b0;

    case (st_q)
      S_INT: begin
        if (is_dig) begin
          len_d = len_inc;
          acc_d = acc_next;
        end else if (c == CH_DOT) begin
          len_d = len_inc;
          st_d  = S_INTDOT;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_NUM; p_tok.val = acc_q; do_sb = 1'b1;
        end
      end
      S_INTDOT: begin
        // "12.." is an integer followed by a range operator.
        if (c == CH_DOT) begin
          p_vld = 1'b1;
          p_tok.kind = K_NUM;
          p_tok.len  = sat_len(len_q - LCW'(1));
          p_tok.val  = acc_q;
          x_vld = 1'b1;
          st_d  = S_START;
        end else if (is_dig) begin
          len_d = len_inc;
          st_d  = S_FRAC;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      S_FRAC: begin
        if (c == CH_LE || c == CH_UE) begin
          len_d = len_inc;
          st_d  = S_EXP;
        end else if (is_dig) begin
          len_d = len_inc;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_RNUM; do_sb = 1'b1;
        end
      end
      S_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          len_d = len_inc;
          st_d  = S_EXPSIGN;
        end else if (is_dig) begin
          len_d = len_inc;
          st_d  = S_EXPDIG;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      S_EXPSIGN: begin
        if (is_dig) begin
          len_d = len_inc;
          st_d  = S_EXPDIG;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      S_EXPDIG: begin
        if (is_dig) begin
          len_d = len_inc;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_RNUM; do_sb = 1'b1;
        end
      end
      S_ID: begin
        if (is_alpha || is_dig || c == CH_UNDER) begin
          len_d = len_inc;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_ID; do_sb = 1'b1;
        end
      end
      S_STAR: begin
        if (c == CH_STAR) begin
          st_d = S_CMT;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_MUL; do_sb = 1'b1;
        end
      end
      S_CMT, S_CMTSTAR: begin
        // End of input inside a comment closes the comment.
        if (c == CH_NUL) begin
          p_vld = 1'b1;
          p_tok.kind  = K_END;
          p_tok.start = pos32;
          p_tok.len   = '0;
          st_d = S_START;
        end else if (c == CH_STAR) begin
          st_d = (st_q == S_CMTSTAR) ? S_START : S_CMTSTAR;
        end else begin
          if (c == CH_NL && line_q != '1) line_d = line_q + LINE_W'(1);
          st_d = S_CMT;
        end
      end
      S_LT: begin
        if (c == CH_EQ) begin
          p_vld = 1'b1; p_tok.kind = K_LE; p_tok.len = LEN_W'(2); st_d = S_START;
        end else if (c == CH_LT) begin
          st_d = S_LTLT;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_LT; do_sb = 1'b1;
        end
      end
      S_LTLT: begin
        if (c == CH_LT) begin
          p_vld = 1'b1; p_tok.kind = K_DRVDEF; p_tok.len = LEN_W'(3); st_d = S_START;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_DEF; p_tok.len = LEN_W'(2); do_sb = 1'b1;
        end
      end
      S_GT: begin
        if (c == CH_EQ) begin
          p_vld = 1'b1; p_tok.kind = K_GE; p_tok.len = LEN_W'(2); st_d = S_START;
        end else if (c == CH_GT) begin
          st_d = S_GTGT;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_GT; do_sb = 1'b1;
        end
      end
      S_GTGT: begin
        if (c == CH_GT) begin
          p_vld = 1'b1; p_tok.kind = K_DRVENDDEF; p_tok.len = LEN_W'(3);
          st_d = S_START;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_ENDDEF; p_tok.len = LEN_W'(2); do_sb = 1'b1;
        end
      end
      S_BANG: begin
        if (c == CH_EQ) begin
          p_vld = 1'b1; p_tok.kind = K_NE; p_tok.len = LEN_W'(2); st_d = S_START;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      S_EQ: begin
        if (c == CH_EQ) begin
          p_vld = 1'b1; p_tok.kind = K_EQ; p_tok.len = LEN_W'(2); st_d = S_START;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      S_COLON: begin
        if (c == CH_EQ) begin
          p_vld = 1'b1; p_tok.kind = K_ASSIGN; p_tok.len = LEN_W'(2); st_d = S_START;
        end else begin
          p_vld = 1'b1; p_tok.kind = K_COLON; do_sb = 1'b1;
        end
      end
      S_DOT: begin
        if (c == CH_DOT) begin
          p_vld = 1'b1; p_tok.kind = K_RANGE; p_tok.len = LEN_W'(2); st_d = S_START;
        end else begin
          p_vld = 1'b1; do_sb = 1'b1;
        end
      end
      default: do_sb = 1'b1;
    endcase

    // The byte that ended a token (or any byte in the start state) is
    // scanned again from the start state.
    if (do_sb) begin
      lst_d = pos_q;
      len_d = LCW'(1);
      st_d  = sb_state;
      if (sb_nl && line_q != '1) line_d = line_q + LINE_W'(1);
      if (sb_dig) acc_d = VAL_W'(c[3:0]);
    end
  end

  always_comb begin
    sb_vld       = do_sb && sb_emit;
    sb_tok.kind  = sb_kind;
    sb_tok.line  = line_q;
    sb_tok.start = pos32;
    sb_tok.len   = sb_len0 ? '0 : LEN_W'(1);
    sb_tok.val   = '0;
    sb_tok.last  = 1'b0;

    if (p_vld) begin
      r0    = p_tok;
      r1    = x_vld ? x_tok : sb_tok;
      n_res = 2'd1 + 2'(x_vld) + 2'(sb_vld);
    end else begin
      r0    = sb_tok;
      r1    = sb_tok;
      n_res = 2'(sb_vld);
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (step) s1_vld_d = 1'b0;
    if (in_acc) s1_vld_d = 1'b1;
    rd_d  = pop ? rd_q + QPW'(1) : rd_q;
    wr_d  = step ? wr_q + QPW'(n_res) : wr_q;
    cnt_d = cnt_q + (step ? QCW'(n_res) : '0) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      st_q     <= S_START;
      pos_q    <= '0;
      lst_q    <= '0;
      line_q   <= LINE_W'(1);
      acc_q    <= '0;
      len_q    <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      cnt_q    <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      cnt_q    <= cnt_d;
      if (step) begin
        st_q   <= st_d;
        pos_q  <= pos_d;
        lst_q  <= lst_d;
        line_q <= line_d;
        acc_q  <= acc_d;
        len_q  <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_byte_q <= in_byte_i;
    if (step && n_res != 2'd0) fifo_q[wr_q] <= r0;
    if (step && n_res == 2'd2) fifo_q[wr_q + QPW'(1)] <= r1;
  end

  assign out_valid_o    = (cnt_q != '0);
  assign token_kind_o   = fifo_q[rd_q].kind;
  assign token_line_o   = fifo_q[rd_q].line;
  assign token_start_o  = fifo_q[rd_q].start;
  assign token_length_o = fifo_q[rd_q].len;
  assign int_value_o    = fifo_q[rd_q].val;
  assign last_of_run_o  = fifo_q[rd_q].last;

endmodule

[hw/rtl/tsd_checker.sv]
// Port-level assertions for the token scanner DFA and their binding.
module tsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  token_kind_o,
  input logic [23:0] token_line_o,
  input logic [31:0] token_start_o,
  input logic [15:0] token_length_o,
  input logic [30:0] int_value_o,
  input logic        last_of_run_o
);
  import tsd_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(token_kind_o) && $stable(token_line_o)
      && $stable(token_start_o) && $stable(token_length_o) && $stable(int_value_o)
      && $stable(last_of_run_o))
    else $error("output item changed while stalled");

  // The input side only stalls while results are waiting to leave.
  a_in_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_end_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_END |-> token_length_o == '0 && last_of_run_o)
    else $error("end item with nonzero length or not last of run");

  a_value_only_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != K_NUM |-> int_value_o == '0)
    else $error("value on an item that is not an integer");

endmodule

bind token_scanner_dfa_unit tsd_checker u_tsd_checker (.*);

[sim/testbench.sv]
// Self-checking testbench of the token scanner DFA: byte stimulus, token prediction and check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Predicts the tokens of each accepted byte and checks the tokens that come out.
  class token_scoreboard;
    scan_state_e st;
    logic [31:0] pos;
    logic [31:0] lex_start;
    logic [23:0] line_no;
    logic [30:0] accum;
    int unsigned lex_len;
    tok_t        expected_q[$];
    tok_t        fresh[$];
    int unsigned errors;

    function new();
      st = S_START;
      pos = '0;
      lex_start = '0;
      line_no = 24'd1;
      accum = '0;
      lex_len = 0;
      errors = 0;
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch: %s", what);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    // A byte causes at most two tokens.
    function void put(kind_e k, logic [31:0] s, int unsigned n, logic [30:0] v);
      tok_t t;
      if (fresh.size() >= 2) return;
      t.kind = k;
      t.line = line_no;
      t.start = s;
      t.len = (n > 65535) ? 16'hFFFF : n[15:0];
      t.val = v;
      t.last = 1'b0;
      fresh.push_back(t);
    endfunction

    function void bump_line();
      if (line_no != 24'hFFFFFF) line_no++;
    endfunction

    function void bump_len();
      if (lex_len != 32'hFFFF_FFFF) lex_len++;
    endfunction

    function void open_lexeme(logic [7:0] c);
      lex_start = pos;
      lex_len = 1;
      st = S_START;
      case (c)
        CH_PLUS:  put(K_PLUS, pos, 1, '0);
        CH_MINUS: put(K_MINUS, pos, 1, '0);
        CH_SLASH: put(K_DIV, pos, 1, '0);
        CH_LSQ:   put(K_SQBO, pos, 1, '0);
        CH_RSQ:   put(K_SQBC, pos, 1, '0);
        CH_LPAR:  put(K_BO, pos, 1, '0);
        CH_RPAR:  put(K_BC, pos, 1, '0);
        CH_COMMA: put(K_COMMA, pos, 1, '0);
        CH_SEMI:  put(K_SEMI, pos, 1, '0);
        CH_BANG:  st = S_BANG;
        CH_EQ:    st = S_EQ;
        CH_COLON: st = S_COLON;
        CH_DOT:   st = S_DOT;
        CH_LT:    st = S_LT;
        CH_GT:    st = S_GT;
        CH_STAR:  st = S_STAR;
        CH_NL:    bump_line();
        CH_TAB, CH_SPACE: ;
        CH_NUL:   put(K_END, pos, 0, '0);
        default: begin
          if (is_alpha(c)) begin
            st = S_ID;
          end else if (is_digit(c)) begin
            st = S_INT;
            accum = 31'(c - CH_ZERO);
          end else begin
            put(K_ERR, pos, 1, '0);
          end
        end
      endcase
    endfunction

    // The pending lexeme ends before this byte, which then starts over.
    function void close_and_rescan(kind_e k, logic [30:0] v, logic [7:0] c);
      put(k, lex_start, lex_len, v);
      open_lexeme(c);
    endfunction

    function void note_byte(logic [7:0] c);
      longint unsigned wide;
      fresh.delete();
      case (st)
        S_INT: begin
          if (is_digit(c)) begin
            bump_len();
            wide = 64'(accum) * 64'd10 + 64'(c - CH_ZERO);
            accum = (wide > 64'(VAL_MAX)) ? VAL_MAX : wide[30:0];
          end else if (c == CH_DOT) begin
            bump_len();
            st = S_INTDOT;
          end else begin
            close_and_rescan(K_NUM, accum, c);
          end
        end
        S_INTDOT: begin
          if (c == CH_DOT) begin
            put(K_NUM, lex_start, lex_len - 1, accum);
            put(K_RANGE, pos - 32'd1, 2, '0);
            st = S_START;
          end else if (is_digit(c)) begin
            bump_len();
            st = S_FRAC;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        S_FRAC: begin
          if (c == CH_LE || c == CH_UE) begin
            bump_len();
            st = S_EXP;
          end else if (is_digit(c)) begin
            bump_len();
          end else begin
            close_and_rescan(K_RNUM, '0, c);
          end
        end
        S_EXP: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            bump_len();
            st = S_EXPSIGN;
          end else if (is_digit(c)) begin
            bump_len();
            st = S_EXPDIG;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        S_EXPSIGN: begin
          if (is_digit(c)) begin
            bump_len();
            st = S_EXPDIG;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        S_EXPDIG: begin
          if (is_digit(c)) bump_len();
          else close_and_rescan(K_RNUM, '0, c);
        end
        S_ID: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) bump_len();
          else close_and_rescan(K_ID, '0, c);
        end
        S_STAR: begin
          if (c == CH_STAR) st = S_CMT;
          else close_and_rescan(K_MUL, '0, c);
        end
        S_CMT, S_CMTSTAR: begin
          if (c == CH_NUL) begin
            put(K_END, pos, 0, '0);
            st = S_START;
          end else if (c == CH_STAR) begin
            st = (st == S_CMTSTAR) ? S_START : S_CMTSTAR;
          end else begin
            if (c == CH_NL) bump_line();
            st = S_CMT;
          end
        end
        S_LT: begin
          if (c == CH_EQ) begin
            put(K_LE, lex_start, 2, '0);
            st = S_START;
          end else if (c == CH_LT) begin
            st = S_LTLT;
          end else begin
            close_and_rescan(K_LT, '0, c);
          end
        end
        S_LTLT: begin
          if (c == CH_LT) begin
            put(K_DRVDEF, lex_start, 3, '0);
            st = S_START;
          end else begin
            lex_len = 2;
            close_and_rescan(K_DEF, '0, c);
          end
        end
        S_GT: begin
          if (c == CH_EQ) begin
            put(K_GE, lex_start, 2, '0);
            st = S_START;
          end else if (c == CH_GT) begin
            st = S_GTGT;
          end else begin
            close_and_rescan(K_GT, '0, c);
          end
        end
        S_GTGT: begin
          if (c == CH_GT) begin
            put(K_DRVENDDEF, lex_start, 3, '0);
            st = S_START;
          end else begin
            lex_len = 2;
            close_and_rescan(K_ENDDEF, '0, c);
          end
        end
        S_BANG: begin
          if (c == CH_EQ) begin
            put(K_NE, lex_start, 2, '0);
            st = S_START;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        S_EQ: begin
          if (c == CH_EQ) begin
            put(K_EQ, lex_start, 2, '0);
            st = S_START;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        S_COLON: begin
          if (c == CH_EQ) begin
            put(K_ASSIGN, lex_start, 2, '0);
            st = S_START;
          end else begin
            close_and_rescan(K_COLON, '0, c);
          end
        end
        S_DOT: begin
          if (c == CH_DOT) begin
            put(K_RANGE, lex_start, 2, '0);
            st = S_START;
          end else begin
            close_and_rescan(K_ERR, '0, c);
          end
        end
        default: open_lexeme(c);
      endcase
      pos++;
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) expected_q.push_back(fresh[i]);
    endfunction

    function void check_token(tok_t got);
      tok_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("token kind %0d at offset %0d with none expected",
                         got.kind, got.start));
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind %0d, expected %0d (offset %0d)", got.kind, exp.kind, exp.start));
      if (got.line !== exp.line)
        report($sformatf("line %0d, expected %0d (offset %0d)", got.line, exp.line, exp.start));
      if (got.start !== exp.start)
        report($sformatf("start %0d, expected %0d", got.start, exp.start));
      if (got.len !== exp.len)
        report($sformatf("length %0d, expected %0d (offset %0d)", got.len, exp.len, exp.start));
      if (got.val !== exp.val)
        report($sformatf("value %0d, expected %0d (offset %0d)", got.val, exp.val, exp.start));
      if (got.last !== exp.last)
        report($sformatf("last %0b, expected %0b (offset %0d)", got.last, exp.last, exp.start));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  token_kind_o;
  logic [23:0] token_line_o;
  logic [31:0] token_start_o;
  logic [15:0] token_length_o;
  logic [30:0] int_value_o;
  logic        last_of_run_o;

  token_scoreboard sb = new();
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  longint unsigned cycles = 0;
  logic [7:0]  frag[$];

  string op_text[23] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=", "<<", ">>",
                         "<<<", ">>>", ":", ":=", "..", ";", ",", "[", "]", "(", ")"};
  string broken_text[10] = '{"12.x", "3.5e;", "3.5E-x", "!", "=", ".", "7..", "1e",
                             "!x", "=+"};

  token_scanner_dfa_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_line_o  (token_line_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .int_value_o   (int_value_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any update made at that edge.
  always @(posedge clk_i) begin
    tok_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind = kind_e'(token_kind_o);
        got.line = token_line_o;
        got.start = token_start_o;
        got.len = token_length_o;
        got.val = int_value_o;
        got.last = last_of_run_o;
        sb.check_token(got);
      end
    end
  end

  // Receiver: random stalls, none while calm, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left = 300;
      hold_go <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 9);
    end
  end

  // Valid stays high from one item to the next unless a gap is taken.
  task automatic feed_byte(logic [7:0] b);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return CH_LA + 8'(r);
    if (r < 52) return CH_UA + 8'(r - 26);
    if (r < 62) return CH_ZERO + 8'(r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed lexemes with random content, some broken ones and noise.
  task automatic build_fragment();
    int r;
    int n;
    string s;
    frag.delete();
    r = $urandom_range(99);
    if (r < 18) begin
      s = op_text[$urandom_range(0, 22)];
      for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
    end else if (r < 34) begin
      n = ($urandom_range(99) < 6) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (n) frag.push_back(digit_char());
    end else if (r < 44) begin
      repeat ($urandom_range(1, 3)) frag.push_back(digit_char());
      frag.push_back(CH_DOT);
      repeat ($urandom_range(1, 3)) frag.push_back(digit_char());
      if ($urandom_range(99) < 60) begin
        frag.push_back($urandom_range(1) ? CH_LE : CH_UE);
        case ($urandom_range(0, 2))
          0: frag.push_back(CH_PLUS);
          1: frag.push_back(CH_MINUS);
          default: ;
        endcase
        repeat ($urandom_range(1, 3)) frag.push_back(digit_char());
      end
    end else if (r < 58) begin
      frag.push_back($urandom_range(1) ? CH_LA + 8'($urandom_range(0, 25))
                                       : CH_UA + 8'($urandom_range(0, 25)));
      repeat ($urandom_range(0, 8)) frag.push_back(ident_char());
    end else if (r < 64) begin
      frag.push_back(CH_STAR);
      frag.push_back(CH_STAR);
      repeat ($urandom_range(0, 12)) begin
        n = $urandom_range(99);
        if (n < 10) frag.push_back(CH_STAR);
        else if (n < 20) frag.push_back(CH_NL);
        else if (n < 23) frag.push_back(CH_NUL);
        else frag.push_back(8'($urandom_range(1, 255)));
      end
      frag.push_back(CH_STAR);
      frag.push_back(CH_STAR);
    end else if (r < 71) begin
      s = broken_text[$urandom_range(0, 9)];
      for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
    end else if (r < 80) begin
      frag.push_back(blank_char());
    end else if (r < 96) begin
      frag.push_back(8'($urandom_range(0, 255)));
    end else begin
      frag.push_back(CH_NUL);
    end
    // Lexemes that abut exercise the rescan of the byte that ends a token.
    if ($urandom_range(99) < 55) frag.push_back(blank_char());
  endtask

  task automatic feed_random_source(int goal);
    int counted;
    counted = 0;
    while (counted < goal) begin
      build_fragment();
      foreach (frag[i]) begin
        feed_byte(frag[i]);
        counted++;
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed part: two dots after digits, broken lexemes, invalid bytes,
    // value saturation and end of input inside a comment.
    feed_text("12..x!a 1.;");
    feed_byte(8'hFF);
    feed_byte(CH_CR);
    feed_byte(8'h80);
    feed_text("4294967296 **");
    feed_byte(CH_NL);
    feed_byte(CH_NUL);

    feed_random_source(700);

    calm <= 1'b1;
    feed_random_source(300);
    calm <= 1'b0;

    // Long receiver hold-off while the sender keeps offering items.
    hold_go <= 1'b1;
    calm <= 1'b1;
    feed_random_source(80);
    calm <= 1'b0;

    // Sender pauses until every expected token has arrived.
    in_valid_i <= 1'b0;
    wait_drained();

    feed_random_source(900);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tsd_pkg.sv
hw/rtl/token_scanner_dfa_unit.sv
hw/rtl/tsd_checker.sv
sim/testbench.sv
